@@ src/bounded_deque_shift_core_assert.svh @@
// Assertion macros shared by the deque checker.
`ifndef BOUNDED_DEQUE_SHIFT_CORE_ASSERT_SVH
`define BOUNDED_DEQUE_SHIFT_CORE_ASSERT_SVH

// Clocked check, suspended while reset is held.
`define BDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define BDQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/bdq_pkg.sv @@
// Shared types and constants for the bounded deque.
package bdq_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int ID_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    MODE_PUSH_TAIL = 2'd0,
    MODE_POP_HEAD  = 2'd1,
    MODE_PUSH_HEAD = 2'd2,
    MODE_POP_TAIL  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Per-cell command for one cycle.
  typedef enum logic [2:0] {
    CMD_HOLD      = 3'd0,
    CMD_LOAD      = 3'd1,
    CMD_CLEAR     = 3'd2,
    CMD_TAKE_PREV = 3'd3,  // shift toward tail
    CMD_TAKE_NEXT = 3'd4   // shift toward head
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      rd_sel;     // drive contents onto the read tap
  } cell_ctrl_t;

endpackage

@@ src/bdq_cell.sv @@
// One storage cell of the deque shift chain.
module bdq_cell #(
  parameter int ID_WIDTH = bdq_pkg::ID_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bdq_pkg::cell_ctrl_t ctrl,
  input  logic [ID_WIDTH-1:0] load_data,
  input  logic [ID_WIDTH-1:0] prev_data,
  input  logic [ID_WIDTH-1:0] next_data,
  output logic [ID_WIDTH-1:0] data,
  output logic [ID_WIDTH-1:0] tap
);
  import bdq_pkg::*;

  logic [ID_WIDTH-1:0] data_r;
  logic [ID_WIDTH-1:0] data_nxt;

  always_comb begin
    unique case (ctrl.cmd)
      CMD_HOLD:      data_nxt = data_r;
      CMD_LOAD:      data_nxt = load_data;
      CMD_CLEAR:     data_nxt = '0;
      CMD_TAKE_PREV: data_nxt = prev_data;
      CMD_TAKE_NEXT: data_nxt = next_data;
      default:       data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data = data_r;
  assign tap  = ctrl.rd_sel ? data_r : '0;

endmodule

@@ src/bounded_deque_shift_core.sv @@
// Top level: bounded double-ended queue built as a chain of shift cells.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------
//  in      | input     | in_valid / in_ready | in_mode, in_item_id
//  out     | output    | out_valid/out_ready | out_popped_id, out_slot_used,
//          |           |                     | out_occupancy, out_status
//
// One operation per cycle while the output is not stalled: a transfer on the
// input updates the addressed cells and the occupancy count at that edge, and
// its result is captured in the output register at that same edge. Input is
// taken whenever the output register is empty or being drained, so a stalled
// result holds the input off only while it waits.
// Synchronous active-low reset clears all cells, the count and out_valid.
module bounded_deque_shift_core #(
  parameter  int DEPTH    = bdq_pkg::DEPTH_DEF,
  parameter  int ID_WIDTH = bdq_pkg::ID_WIDTH_DEF,
  localparam int SLOT_W   = $clog2(DEPTH),
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_mode,
  input  logic [ID_WIDTH-1:0] in_item_id,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ID_WIDTH-1:0] out_popped_id,
  output logic [SLOT_W-1:0]   out_slot_used,
  output logic [CNT_W-1:0]    out_occupancy,
  output logic [1:0]          out_status
);
  import bdq_pkg::*;

  // Control
  logic             fire;
  mode_t            mode;
  logic             full;
  logic             empty;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;

  // Result register
  logic [ID_WIDTH-1:0] popped_r;
  logic [ID_WIDTH-1:0] popped_nxt;
  logic [SLOT_W-1:0]   slot_r;
  logic [SLOT_W-1:0]   slot_nxt;
  status_t             status_r;
  status_t             status_nxt;
  logic [CNT_W-1:0]    occ_r;

  // Chain wiring
  cell_ctrl_t          ctrl    [DEPTH];
  logic [ID_WIDTH-1:0] cell_q  [DEPTH];
  logic [ID_WIDTH-1:0] cell_tap[DEPTH];
  logic [ID_WIDTH-1:0] prev_d  [DEPTH];
  logic [ID_WIDTH-1:0] next_d  [DEPTH];
  logic [ID_WIDTH-1:0] tap_or;

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;
  assign mode     = mode_t'(in_mode);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);

  // Per-cell commands. Tail-side ops load or clear only the cell at the tail
  // boundary; head-side ops move the whole row one place, a head push loading cell 0.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i].cmd    = CMD_HOLD;
      ctrl[i].rd_sel = (mode == MODE_POP_HEAD) ? (i == 0)
                                               : (count_r == CNT_W'(i + 1));
      if (fire) begin
        unique case (mode)
          MODE_PUSH_TAIL: begin
            if (!full && (count_r == CNT_W'(i))) ctrl[i].cmd = CMD_LOAD;
          end
          MODE_POP_HEAD: begin
            if (!empty) ctrl[i].cmd = CMD_TAKE_NEXT;
          end
          MODE_PUSH_HEAD: begin
            if (!full) ctrl[i].cmd = (i == 0) ? CMD_LOAD : CMD_TAKE_PREV;
          end
          MODE_POP_TAIL: begin
            if (!empty && (count_r == CNT_W'(i + 1))) ctrl[i].cmd = CMD_CLEAR;
          end
        endcase
      end
    end
  end

  // Cell row; the ends see zero beyond the last slot.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev_d[g] = '0;
    end else begin : g_mid_p
      assign prev_d[g] = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign next_d[g] = '0;
    end else begin : g_mid_n
      assign next_d[g] = cell_q[g+1];
    end

    bdq_cell #(
      .ID_WIDTH(ID_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl[g]),
      .load_data(in_item_id),
      .prev_data(prev_d[g]),
      .next_data(next_d[g]),
      .data     (cell_q[g]),
      .tap      (cell_tap[g])
    );
  end

  // One-hot read select: at most one tap is nonzero.
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  // Result and count update
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    slot_nxt   = '0;
    popped_nxt = '0;
    unique case (mode)
      MODE_PUSH_TAIL: begin
        if (full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          slot_nxt  = count_r[SLOT_W-1:0];
          count_nxt = count_r + CNT_W'(1);
        end
      end
      MODE_PUSH_HEAD: begin
        if (full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      MODE_POP_HEAD, MODE_POP_TAIL: begin
        if (empty) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          popped_nxt = tap_or;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r <= count_nxt;
      end
      if (in_ready) begin
        out_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      popped_r <= popped_nxt;
      slot_r   <= slot_nxt;
      status_r <= status_nxt;
      occ_r    <= count_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_popped_id = popped_r;
  assign out_slot_used = slot_r;
  assign out_occupancy = occ_r;
  assign out_status    = status_r;

endmodule

@@ src/bdq_checker.sv @@
// Port-level checks for the bounded deque, bound to the top level.
`include "bounded_deque_shift_core_assert.svh"

module bdq_checker #(
  parameter  int DEPTH    = bdq_pkg::DEPTH_DEF,
  parameter  int ID_WIDTH = bdq_pkg::ID_WIDTH_DEF,
  localparam int SLOT_W   = $clog2(DEPTH),
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [ID_WIDTH-1:0] out_popped_id,
  input logic [SLOT_W-1:0]   out_slot_used,
  input logic [CNT_W-1:0]    out_occupancy,
  input logic [1:0]          out_status
);
  import bdq_pkg::*;

  logic                               stalled;
  logic [ID_WIDTH+SLOT_W+CNT_W+2-1:0] out_payload;
  logic                               rejected;
  logic                               no_data;
  logic                               occ_full;
  logic                               occ_empty;
  logic                               occ_legal;
  logic                               status_fits;

  assign stalled     = out_valid && !out_ready;
  assign out_payload = {out_popped_id, out_slot_used, out_occupancy, out_status};
  assign rejected    = out_valid && (out_status != ST_OK);
  assign no_data     = (out_popped_id == '0) && (out_slot_used == '0);
  assign occ_full    = (out_occupancy == CNT_W'(DEPTH));
  assign occ_empty   = (out_occupancy == '0);
  assign occ_legal   = (out_occupancy <= CNT_W'(DEPTH));
  assign status_fits = (out_status == ST_OVERFLOW)  ? occ_full  :
                       (out_status == ST_UNDERFLOW) ? occ_empty : occ_legal;

  // Stalled result holds its payload.
  `BDQ_ASSERT(a_out_hold, stalled |=> out_valid && $stable(out_payload), "stalled result changed")

  // Rejected operations report no data and no slot.
  `BDQ_ASSERT(a_reject_clean, rejected |-> no_data, "rejected op carries data")

  // Overflow only when full, underflow only when empty.
  `BDQ_ASSERT(a_status_occ, out_valid |-> status_fits, "status disagrees with occupancy")

  // Input is never refused while the output side is empty.
  `BDQ_ASSERT_ALWAYS(a_ready_idle, !out_valid |-> in_ready, "input stalled with empty output")

endmodule

bind bounded_deque_shift_core bdq_checker #(
  .DEPTH   (DEPTH),
  .ID_WIDTH(ID_WIDTH)
) u_bdq_checker (.*);

@@ dv/tb_bounded_deque_shift_core.sv @@
// Self-checking testbench for the bounded deque shift core.
`timescale 1ns / 100ps

module tb_bounded_deque_shift_core;
  import bdq_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int ID_W        = ID_WIDTH_DEF;
  localparam int SLOT_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int HOLD_CYCLES = 120;     // receiver hold-off in the backpressure test
  localparam int CYCLE_LIMIT = 500000;  // far beyond the slowest legal run
  localparam int PRINT_CAP   = 50;      // mismatch lines printed before going quiet

  // Expected result of one operation, laid out like the output ports.
  typedef struct packed {
    logic [ID_W-1:0]   popped_id;
    logic [SLOT_W-1:0] slot_used;
    logic [CNT_W-1:0]  occupancy;
    status_t           status;
  } deque_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_mode = MODE_PUSH_TAIL;
  logic [ID_W-1:0]   in_item_id = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ID_W-1:0]   out_popped_id;
  logic [SLOT_W-1:0] out_slot_used;
  logic [CNT_W-1:0]  out_occupancy;
  logic [1:0]        out_status;

  // Shadow deque: slot 0 is the head, slots at or above the count hold zero.
  logic [ID_W-1:0] shadow_slots [DEPTH];
  int              shadow_count = 0;
  deque_result_t   pending_results [$];

  int   err_count = 0;
  int   cycle_count = 0;
  bit   send_gaps_on = 1'b1;
  bit   recv_stalls_on = 1'b1;
  bit   hold_req = 1'b0;
  int   hold_left = 0;
  int   stall_left = 0;

  bounded_deque_shift_core #(
    .DEPTH    (DEPTH),
    .ID_WIDTH (ID_W)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_item_id    (in_item_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_popped_id (out_popped_id),
    .out_slot_used (out_slot_used),
    .out_occupancy (out_occupancy),
    .out_status    (out_status)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bounded_deque_shift_core: mismatch");
      $finish;
    end
  end

  // Gap length: mostly none, often short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Identifier mix: full random plus all-zero, all-one and single-bit patterns.
  function automatic logic [ID_W-1:0] pick_id();
    logic [ID_W-1:0] one_hot;
    one_hot = '0;
    one_hot[$urandom_range(0, ID_W - 1)] = 1'b1;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return one_hot;
      3: return ~one_hot;
      default: return ID_W'($urandom);
    endcase
  endfunction

  // Apply one operation to the shadow deque and return what the core must report.
  function automatic deque_result_t apply_op(mode_t op, logic [ID_W-1:0] id);
    deque_result_t res;
    res = '0;
    res.status = ST_OK;
    case (op)
      MODE_PUSH_TAIL: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_OVERFLOW;
        end else begin
          res.slot_used = SLOT_W'(shadow_count);
          shadow_slots[shadow_count] = id;
          shadow_count++;
        end
      end
      MODE_POP_HEAD: begin
        if (shadow_count == 0) begin
          res.status = ST_UNDERFLOW;
        end else begin
          res.popped_id = shadow_slots[0];
          for (int i = 0; i < DEPTH - 1; i++) shadow_slots[i] = shadow_slots[i + 1];
          shadow_slots[DEPTH - 1] = '0;
          shadow_count--;
        end
      end
      MODE_PUSH_HEAD: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_OVERFLOW;
        end else begin
          // entries move one slot toward the tail, new id lands at the head
          for (int i = DEPTH - 1; i > 0; i--) shadow_slots[i] = shadow_slots[i - 1];
          shadow_slots[0] = id;
          res.slot_used = '0;
          shadow_count++;
        end
      end
      default: begin  // pop at the tail
        if (shadow_count == 0) begin
          res.status = ST_UNDERFLOW;
        end else begin
          res.popped_id = shadow_slots[shadow_count - 1];
          shadow_slots[shadow_count - 1] = '0;
          shadow_count--;
        end
      end
    endcase
    res.occupancy = CNT_W'(shadow_count);
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    if (err_count < PRINT_CAP) $display("%0t ns: %s", $time, msg);
    err_count++;
  endtask

  // Monitor and scoreboard. Both channels are sampled at the rising edge;
  // since the result is registered, a result leaving now never belongs to an input
  // accepted at this same edge, so it is checked before the new entry is queued.
  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing expected (popped %0h)",
                                    out_popped_id));
        end else begin
          want = pending_results.pop_front();
          if (out_popped_id !== want.popped_id)
            report_mismatch($sformatf("popped_id got %0h expected %0h",
                                      out_popped_id, want.popped_id));
          if (out_slot_used !== want.slot_used)
            report_mismatch($sformatf("slot_used got %0d expected %0d",
                                      out_slot_used, want.slot_used));
          if (out_occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy got %0d expected %0d",
                                      out_occupancy, want.occupancy));
          if (out_status !== 2'(want.status))
            report_mismatch($sformatf("status got %0d expected %0d",
                                      out_status, want.status));
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(apply_op(mode_t'(in_mode), in_item_id));
    end
  end

  // Receiver: random stalls of mixed length, plus a long hold-off on request
  // that this process counts down on its own.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (recv_stalls_on && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left = pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // One input transfer, then an optional idle gap. With no gap, valid stays
  // high and the next call only swaps the payload at the next falling edge.
  task automatic send_op(mode_t op, logic [ID_W-1:0] id);
    int gap;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_mode    <= op;
    in_item_id <= id;
    do @(posedge clk); while (!in_ready);
    gap = send_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Sender pause: stop offering and let every outstanding result come back.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Empty-queue pops, id extremes at both ends, every operation.
  task automatic test_corner_ops();
    send_op(MODE_POP_HEAD,  32'h1234_5678);   // underflow, id ignored
    send_op(MODE_POP_TAIL,  '1);              // underflow
    send_op(MODE_PUSH_TAIL, '0);
    send_op(MODE_PUSH_TAIL, '1);
    send_op(MODE_PUSH_HEAD, 32'h8000_0000);
    send_op(MODE_PUSH_HEAD, 32'h0000_0001);
    send_op(MODE_POP_HEAD,  '0);
    send_op(MODE_POP_TAIL,  '0);
    send_op(MODE_POP_HEAD,  '0);
    send_op(MODE_POP_TAIL,  '0);
    send_op(MODE_POP_TAIL,  '0);              // underflow, queue already empty
    send_op(MODE_PUSH_HEAD, 32'h5A5A_5A5A);   // head push into empty queue
    send_op(MODE_POP_TAIL,  '0);
    send_op(MODE_PUSH_TAIL, 32'hA5A5_A5A5);
    send_op(MODE_POP_HEAD,  '0);
    wait_for_results();
  endtask

  // Fill to the full depth, hit overflow from both ends, then empty it out.
  task automatic test_full_boundary();
    for (int i = 0; i < DEPTH; i++)
      send_op((i % 2) ? MODE_PUSH_HEAD : MODE_PUSH_TAIL, pick_id());
    send_op(MODE_PUSH_TAIL, '1);              // overflow
    send_op(MODE_PUSH_HEAD, '1);              // overflow
    send_op(MODE_POP_TAIL,  '0);
    send_op(MODE_PUSH_HEAD, pick_id());       // last free slot
    send_op(MODE_PUSH_TAIL, pick_id());       // overflow again
    for (int i = 0; i < DEPTH; i++)
      send_op((i % 2) ? MODE_POP_TAIL : MODE_POP_HEAD, '0);
    send_op(MODE_POP_HEAD, '0);               // underflow
    wait_for_results();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the result register fills and the input stalls.
  task automatic test_backpressure();
    send_gaps_on = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++)
      send_op(($urandom_range(0, 3) != 0) ? MODE_PUSH_TAIL : MODE_POP_HEAD, pick_id());
    send_gaps_on = 1'b1;
    wait_for_results();
  endtask

  // Random traffic in chunks; the push share swings per chunk so the queue
  // wanders between empty and full, and idling is switched off in some chunks.
  task automatic test_random_traffic();
    int push_pct;
    bit do_push;
    for (int chunk = 0; chunk < 14; chunk++) begin
      case (chunk % 5)
        0: push_pct = 85;
        1: push_pct = 15;
        2: push_pct = 50;
        3: push_pct = 97;
        default: push_pct = 3;
      endcase
      send_gaps_on   = (chunk % 4) != 3;
      recv_stalls_on = (chunk % 3) != 2;
      for (int n = 0; n < 64; n++) begin
        do_push = $urandom_range(0, 99) < push_pct;
        if (do_push)
          send_op($urandom_range(0, 1) ? MODE_PUSH_HEAD : MODE_PUSH_TAIL, pick_id());
        else
          send_op($urandom_range(0, 1) ? MODE_POP_HEAD : MODE_POP_TAIL, pick_id());
      end
      if ($urandom_range(0, 2) == 0) wait_for_results();
    end
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
    wait_for_results();
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) shadow_slots[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_corner_ops();
    test_full_boundary();
    test_backpressure();
    test_random_traffic();

    repeat (4) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("bounded_deque_shift_core: match");
    end else begin
      $display("bounded_deque_shift_core: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/bdq_pkg.sv
src/bdq_cell.sv
src/bounded_deque_shift_core.sv
src/bdq_checker.sv
dv/tb_bounded_deque_shift_core.sv
